// ----- rtl/cpc_pkg.sv -----
// Shared types and constants for the color pulse classifier.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

   // Field widths fixed by the register map and the result format.
   localparam int CAL_W      = 16;
   localparam int SETTLE_W   = 24;
   localparam int VAL_W      = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Request queue depth between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RED_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_HIGH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE     = 3'd6;

   // Color codes, in measurement order.
   localparam logic [1:0] COLOR_RED   = 2'd0;
   localparam logic [1:0] COLOR_GREEN = 2'd1;
   localparam logic [1:0] COLOR_BLUE  = 2'd2;

   // One request as it travels through the queue.
   typedef struct packed {
      logic start_req;
      logic sensor_level;
   } req_item_type;

   // Calibration and timing registers handed to the back end.
   typedef struct packed {
      logic [2:0][CAL_W-1:0] low;
      logic [2:0][CAL_W-1:0] high;
      logic [SETTLE_W-1:0]   settle;
   } cal_regs_type;

endpackage

`default_nettype wire

// ----- rtl/cpc_req_queue.sv -----
// Front end: a small request queue that decouples the input channel from the back end.
// Depends on cpc_pkg for the request item type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module cpc_req_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_start_req,
   input  wire                  req_sensor_level,
   output logic                 q_valid,
   output cpc_pkg::req_item_type q_item,
   input  wire                  q_pop
);

   localparam int PTR_W = $clog2(cpc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(cpc_pkg::QUEUE_DEPTH + 1);

   cpc_pkg::req_item_type entry_ff [cpc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push;

   // Full queue stalls the sender; the stall comes from a register only.
   assign req_stall = (count_ff == CNT_W'(cpc_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(cpc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(cpc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{start_req: req_start_req, sensor_level: req_sensor_level};
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cpc_divider.sv -----
// Iterative restoring divider that maps a scaled count onto the signed intensity value.
// Depends on cpc_pkg for the value and calibration widths; one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cpc_divider #(
   parameter int NUM_W = 24
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire         [NUM_W-1:0]            num_mag,
   input  wire         [cpc_pkg::CAL_W-1:0]   den_mag,
   input  wire                                neg,
   output logic                               done,
   output logic signed [cpc_pkg::VAL_W-1:0]   value
);

   localparam int STEP_W = $clog2(NUM_W + 1);
   localparam int V_W    = NUM_W + 2;
   localparam logic signed [V_W-1:0] V_MAX =
      V_W'((64'sd1 <<< (cpc_pkg::VAL_W - 1)) - 64'sd1);
   localparam logic signed [V_W-1:0] V_MIN = -V_MAX - V_W'(1);
   localparam logic signed [V_W-1:0] V_TOP = V_W'(255);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_SHIFT,
      DV_FINISH
   } dv_state_type;

   dv_state_type                      state_ff, state_in;
   logic [NUM_W-1:0]                  quo_ff, quo_in;
   logic [cpc_pkg::CAL_W-1:0]         rem_ff, rem_in;
   logic [cpc_pkg::CAL_W-1:0]         den_ff;
   logic                              neg_ff;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic                              done_ff, done_in;
   logic signed [cpc_pkg::VAL_W-1:0]  value_ff, value_in;
   logic [cpc_pkg::CAL_W:0]           trial;
   logic [cpc_pkg::CAL_W:0]           trial_sub;
   logic signed [V_W-1:0]             quo_s;
   logic signed [V_W-1:0]             mapped;

   // One restoring step: bring down the next numerator bit and try the divisor.
   assign trial     = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};

   // Signed result around 255, then saturation to the value range.
   assign quo_s  = signed'({2'b00, quo_ff});
   assign mapped = neg_ff ? (V_TOP - quo_s) : (V_TOP + quo_s);

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               quo_in   = num_mag;
               rem_in   = '0;
               step_in  = '0;
               state_in = DV_SHIFT;
            end
         end
         DV_SHIFT: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial_sub[cpc_pkg::CAL_W-1:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[cpc_pkg::CAL_W-1:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               state_in = DV_FINISH;
            end
         end
         DV_FINISH: begin
            // Equal calibration limits force the value to zero.
            if (den_ff == '0) begin
               value_in = '0;
            end else if (mapped > V_MAX) begin
               value_in = V_MAX[cpc_pkg::VAL_W-1:0];
            end else if (mapped < V_MIN) begin
               value_in = V_MIN[cpc_pkg::VAL_W-1:0];
            end else begin
               value_in = mapped[cpc_pkg::VAL_W-1:0];
            end
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      value_ff <= value_in;
      if (state_ff == DV_IDLE && start) begin
         den_ff <= den_mag;
         neg_ff <= neg;
      end
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

// ----- rtl/cpc_core.sv -----
// Back end: the measurement sequencer, the result register and the value mapping.
// Depends on cpc_pkg and instantiates cpc_divider for the calibration mapping.
`timescale 1ns / 1ps
`default_nettype none

module cpc_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                q_valid,
   input  cpc_pkg::req_item_type              q_item,
   output logic                               q_pop,
   input  cpc_pkg::cal_regs_type              cal,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_filter_s2,
   output logic                               rsp_filter_s3,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic                               rsp_red_detected,
   output logic signed [cpc_pkg::VAL_W-1:0]   rsp_red_value,
   output logic signed [cpc_pkg::VAL_W-1:0]   rsp_green_value,
   output logic signed [cpc_pkg::VAL_W-1:0]   rsp_blue_value
);

   localparam int MAG_W = (COUNT_WIDTH > cpc_pkg::CAL_W) ? COUNT_WIDTH : cpc_pkg::CAL_W;
   localparam int NUM_W = MAG_W + 8;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT_HIGH,
      PH_WAIT_FALL,
      PH_COUNT_LOW,
      PH_SETTLE
   } phase_type;

   typedef enum logic {
      EX_RUN,
      EX_MAP
   } exec_type;

   phase_type                         phase_ff, phase_in;
   exec_type                          exec_ff, exec_in;
   logic [1:0]                        color_ff, color_in;
   logic [COUNT_WIDTH-1:0]            low_cnt_ff, low_cnt_in;
   logic [cpc_pkg::SETTLE_W-1:0]      settle_ff, settle_in;
   logic signed [cpc_pkg::VAL_W-1:0]  val_ff [3];
   logic signed [cpc_pkg::VAL_W-1:0]  val_in [3];
   logic                              red_ff, red_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              out_s2_ff, out_s3_ff, out_busy_ff, out_done_ff;
   logic                              out_red_ff;
   logic signed [cpc_pkg::VAL_W-1:0]  out_val_ff [3];
   logic                              out_free;
   logic                              emit;
   logic                              done_flag;
   logic                              advance;
   logic                              div_start;
   logic                              div_done;
   logic signed [cpc_pkg::VAL_W-1:0]  div_value;
   logic [cpc_pkg::CAL_W-1:0]         lo_sel, hi_sel;
   logic [MAG_W-1:0]                  cnt_ext, lo_ext, diff_mag;
   logic [NUM_W-1:0]                  num_mag;
   logic [cpc_pkg::CAL_W-1:0]         den_mag;
   logic                              map_neg;

   // Calibration limits of the color being measured.
   always_comb begin
      case (color_ff)
         cpc_pkg::COLOR_GREEN: begin
            lo_sel = cal.low[1];
            hi_sel = cal.high[1];
         end
         cpc_pkg::COLOR_BLUE: begin
            lo_sel = cal.low[2];
            hi_sel = cal.high[2];
         end
         default: begin
            lo_sel = cal.low[0];
            hi_sel = cal.high[0];
         end
      endcase
   end

   // Divider operands: |count - low| * 255 over |high - low|, with the sign kept apart.
   assign cnt_ext  = MAG_W'(low_cnt_ff);
   assign lo_ext   = MAG_W'(lo_sel);
   assign diff_mag = (cnt_ext > lo_ext) ? (cnt_ext - lo_ext) : (lo_ext - cnt_ext);
   assign num_mag  = {diff_mag, 8'b0} - NUM_W'(diff_mag);
   assign den_mag  = (hi_sel >= lo_sel) ? (hi_sel - lo_sel) : (lo_sel - hi_sel);
   assign map_neg  = (cnt_ext > lo_ext) ^ (hi_sel < lo_sel);

   cpc_divider #(
      .NUM_W (NUM_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_mag (num_mag),
      .den_mag (den_mag),
      .neg     (map_neg),
      .done    (div_done),
      .value   (div_value)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer: one request per step, except the step that closes a low pulse,
   // which waits for the divider before its result is produced.
   always_comb begin
      phase_in   = phase_ff;
      exec_in    = exec_ff;
      color_in   = color_ff;
      low_cnt_in = low_cnt_ff;
      settle_in  = settle_ff;
      val_in     = val_ff;
      red_in     = red_ff;
      q_pop      = 1'b0;
      div_start  = 1'b0;
      emit       = 1'b0;
      advance    = 1'b0;
      done_flag  = 1'b0;
      case (exec_ff)
         EX_RUN: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               emit  = 1'b1;
               case (phase_ff)
                  PH_IDLE: begin
                     if (q_item.start_req) begin
                        color_in = cpc_pkg::COLOR_RED;
                        phase_in = PH_WAIT_HIGH;
                     end
                  end
                  PH_WAIT_HIGH: begin
                     if (q_item.sensor_level) begin
                        phase_in = PH_WAIT_FALL;
                     end
                  end
                  PH_WAIT_FALL: begin
                     if (!q_item.sensor_level) begin
                        low_cnt_in = COUNT_WIDTH'(1);
                        phase_in   = PH_COUNT_LOW;
                     end
                  end
                  PH_COUNT_LOW: begin
                     if (!q_item.sensor_level) begin
                        if (low_cnt_ff != '1) begin
                           low_cnt_in = low_cnt_ff + 1'b1;
                        end
                     end else begin
                        emit      = 1'b0;
                        div_start = 1'b1;
                        exec_in   = EX_MAP;
                     end
                  end
                  PH_SETTLE: begin
                     if (settle_ff != '0) begin
                        settle_in = settle_ff - 1'b1;
                     end
                     if (settle_ff <= cpc_pkg::SETTLE_W'(1)) begin
                        advance = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         EX_MAP: begin
            // The result register was emptied when the pulse-ending request was taken.
            if (div_done) begin
               emit    = 1'b1;
               exec_in = EX_RUN;
               case (color_ff)
                  cpc_pkg::COLOR_GREEN: val_in[1] = div_value;
                  cpc_pkg::COLOR_BLUE:  val_in[2] = div_value;
                  default:              val_in[0] = div_value;
               endcase
               settle_in = cal.settle;
               if (cal.settle == '0) begin
                  advance = 1'b1;
               end else begin
                  phase_in = PH_SETTLE;
               end
            end
         end
         default: begin
            exec_in = EX_RUN;
         end
      endcase

      // Move on to the next color, or classify after blue.
      if (advance) begin
         if (color_ff < cpc_pkg::COLOR_BLUE) begin
            color_in = color_ff + 1'b1;
            phase_in = PH_WAIT_HIGH;
         end else begin
            red_in    = (val_in[0] > val_in[1]) && (val_in[0] > val_in[2]);
            phase_in  = PH_IDLE;
            done_flag = 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         exec_ff      <= EX_RUN;
         color_ff     <= cpc_pkg::COLOR_RED;
         low_cnt_ff   <= '0;
         settle_ff    <= '0;
         red_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            val_ff[i] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         exec_ff      <= exec_in;
         color_ff     <= color_in;
         low_cnt_ff   <= low_cnt_in;
         settle_ff    <= settle_in;
         red_ff       <= red_in;
         rsp_valid_ff <= rsp_valid_in;
         val_ff       <= val_in;
      end
      if (emit) begin
         out_s2_ff   <= (color_in == cpc_pkg::COLOR_GREEN);
         out_s3_ff   <= (color_in == cpc_pkg::COLOR_GREEN) || (color_in == cpc_pkg::COLOR_BLUE);
         out_busy_ff <= (phase_in != PH_IDLE);
         out_done_ff <= done_flag;
         out_red_ff  <= red_in;
         out_val_ff  <= val_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filter_s2    = out_s2_ff;
   assign rsp_filter_s3    = out_s3_ff;
   assign rsp_busy_res     = out_busy_ff;
   assign rsp_done_res     = out_done_ff;
   assign rsp_red_detected = out_red_ff;
   assign rsp_red_value    = out_val_ff[0];
   assign rsp_green_value  = out_val_ff[1];
   assign rsp_blue_value   = out_val_ff[2];

endmodule

`default_nettype wire

// ----- rtl/color_pulse_classifier.sv -----
// Top level of the color pulse classifier: configuration registers, request queue, back end.
// Depends on cpc_pkg, cpc_req_queue and cpc_core.
//
//   Channel   Direction  Handshake              Contents
//   req_*     in         req_valid / req_stall  start_req, sensor_level (one sample per tick)
//   rsp_*     out        rsp_valid / rsp_stall  filter lines, busy, done, red flag, 3 values
//   csr_*     in         csr_valid / csr_ready  register index, write data (always ready)
//
// Every request yields one response, normally registered in the cycle after it leaves the queue.
// The request that ends a low pulse runs the calibration divider, a restoring divider that
// yields one quotient bit per cycle, and its response waits for the divider's result.
// A two-entry request queue keeps taking requests while a response is stalled, until it is full.
// Reset is synchronous and active high; it restores the calibration defaults.
`timescale 1ns / 1ps
`default_nettype none

module color_pulse_classifier #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_start_req,
   input  wire                                   req_sensor_level,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_filter_s2,
   output logic                                  rsp_filter_s3,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic                                  rsp_red_detected,
   output logic signed [cpc_pkg::VAL_W-1:0]      rsp_red_value,
   output logic signed [cpc_pkg::VAL_W-1:0]      rsp_green_value,
   output logic signed [cpc_pkg::VAL_W-1:0]      rsp_blue_value,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire         [cpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire         [cpc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   cpc_pkg::cal_regs_type cal_ff;
   cpc_pkg::req_item_type q_item;
   logic                  q_valid;
   logic                  q_pop;
   logic [cpc_pkg::CAL_W-1:0] wdata_cal;

   assign csr_ready = 1'b1;
   assign wdata_cal = csr_wdata[cpc_pkg::CAL_W-1:0];

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.low[0]  <= 16'd410;
         cal_ff.high[0] <= 16'd830;
         cal_ff.low[1]  <= 16'd660;
         cal_ff.high[1] <= 16'd1220;
         cal_ff.low[2]  <= 16'd610;
         cal_ff.high[2] <= 16'd810;
         cal_ff.settle  <= 24'd100000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cpc_pkg::CSR_RED_LOW:    cal_ff.low[0]  <= wdata_cal;
            cpc_pkg::CSR_RED_HIGH:   cal_ff.high[0] <= wdata_cal;
            cpc_pkg::CSR_GREEN_LOW:  cal_ff.low[1]  <= wdata_cal;
            cpc_pkg::CSR_GREEN_HIGH: cal_ff.high[1] <= wdata_cal;
            cpc_pkg::CSR_BLUE_LOW:   cal_ff.low[2]  <= wdata_cal;
            cpc_pkg::CSR_BLUE_HIGH:  cal_ff.high[2] <= wdata_cal;
            cpc_pkg::CSR_SETTLE:     cal_ff.settle  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Front end: request queue.
   cpc_req_queue u_queue (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_req    (req_start_req),
      .req_sensor_level (req_sensor_level),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   // Back end: sequencer, mapping and response register.
   cpc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .cal              (cal_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filter_s2    (rsp_filter_s2),
      .rsp_filter_s3    (rsp_filter_s3),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_red_detected (rsp_red_detected),
      .rsp_red_value    (rsp_red_value),
      .rsp_green_value  (rsp_green_value),
      .rsp_blue_value   (rsp_blue_value)
   );

endmodule

`default_nettype wire

// ----- bench/color_pulse_classifier_tb.sv -----
// Self-checking testbench for the color pulse classifier: directed and random sensor sequences.
// Depends on cpc_pkg and the color_pulse_classifier top level; refers to no other module directly.
`timescale 1ns / 1ps

module color_pulse_classifier_tb;

   // Local copies of the package widths, used for size casts.
   localparam int CAL_W    = cpc_pkg::CAL_W;
   localparam int SETTLE_W = cpc_pkg::SETTLE_W;
   localparam int VAL_W    = cpc_pkg::VAL_W;
   localparam int IDX_W    = cpc_pkg::CSR_IDX_W;
   localparam int DATA_W   = cpc_pkg::CSR_DATA_W;

   localparam longint LOW_TICKS_MAX = 64'sd65535;
   localparam longint VAL_HI = 64'sd16777215;
   localparam longint VAL_LO = -64'sd16777216;
   localparam int unsigned TOTAL_ITEMS = 1450;
   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int unsigned END_WAIT = 40;
   localparam logic [IDX_W-1:0] CSR_UNUSED = 3'd7;

   // Measurement sequencer phases of the predictor.
   typedef enum logic [2:0] {
      MP_IDLE, MP_SEEK_HIGH, MP_SEEK_FALL, MP_LOW, MP_SETTLE
   } meas_phase_type;

   // One response as the block should show it.
   typedef struct packed {
      logic                    filter_s2;
      logic                    filter_s3;
      logic                    busy;
      logic                    done;
      logic                    red_detected;
      logic signed [VAL_W-1:0] red_value;
      logic signed [VAL_W-1:0] green_value;
      logic signed [VAL_W-1:0] blue_value;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_start_req = 1'b0;
   logic req_sensor_level = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;
   logic req_stall, rsp_valid, csr_ready;
   logic rsp_filter_s2, rsp_filter_s3, rsp_busy_res, rsp_done_res, rsp_red_detected;
   logic signed [VAL_W-1:0] rsp_red_value, rsp_green_value, rsp_blue_value;

   // Predictor copy of the registers and the sequencer state.
   logic [CAL_W-1:0] cal_lo [3];
   logic [CAL_W-1:0] cal_hi [3];
   logic [SETTLE_W-1:0] settle_cfg;
   meas_phase_type meas_phase;
   logic [1:0] meas_color;
   longint low_ticks;
   logic [SETTLE_W-1:0] settle_left;
   longint mapped [3];
   logic red_flag;

   reading_type expected_readings [$];
   int unsigned mismatch_count = 0;
   int unsigned sent_items = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_hold = 0;
   bit gaps_off = 1'b0;

   color_pulse_classifier u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_req    (req_start_req),
      .req_sensor_level (req_sensor_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filter_s2    (rsp_filter_s2),
      .rsp_filter_s3    (rsp_filter_s3),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_red_detected (rsp_red_detected),
      .rsp_red_value    (rsp_red_value),
      .rsp_green_value  (rsp_green_value),
      .rsp_blue_value   (rsp_blue_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Free-running 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Random idle length: mostly none, sometimes short, rarely long.
   function automatic int unsigned pick_gap(int unsigned longest);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (gaps_off || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, longest);
   endfunction

   function automatic bit coin();
      return ($urandom_range(0, 1) == 1);
   endfunction

   // Linear map of a low count onto 255 down to 0 between the calibration limits.
   function automatic longint scale_count(longint cnt, longint lo, longint hi);
      longint span;
      longint v;
      span = hi - lo;
      if (span == 64'sd0) return 64'sd0;
      v = ((cnt - lo) * -64'sd255) / span + 64'sd255;
      if (v > VAL_HI) v = VAL_HI;
      if (v < VAL_LO) v = VAL_LO;
      return v;
   endfunction

   function automatic void reset_predictor();
      cal_lo[cpc_pkg::COLOR_RED] = 16'd410;    cal_hi[cpc_pkg::COLOR_RED] = 16'd830;
      cal_lo[cpc_pkg::COLOR_GREEN] = 16'd660;  cal_hi[cpc_pkg::COLOR_GREEN] = 16'd1220;
      cal_lo[cpc_pkg::COLOR_BLUE] = 16'd610;   cal_hi[cpc_pkg::COLOR_BLUE] = 16'd810;
      settle_cfg = 24'd100000;
      meas_phase = MP_IDLE;
      meas_color = cpc_pkg::COLOR_RED;
      low_ticks = 64'sd0;
      settle_left = '0;
      mapped[cpc_pkg::COLOR_RED] = 64'sd0;
      mapped[cpc_pkg::COLOR_GREEN] = 64'sd0;
      mapped[cpc_pkg::COLOR_BLUE] = 64'sd0;
      red_flag = 1'b0;
   endfunction

   function automatic void store_register(logic [IDX_W-1:0] idx,
                                          logic [DATA_W-1:0] data);
      case (idx)
         cpc_pkg::CSR_RED_LOW:    cal_lo[cpc_pkg::COLOR_RED] = data[CAL_W-1:0];
         cpc_pkg::CSR_RED_HIGH:   cal_hi[cpc_pkg::COLOR_RED] = data[CAL_W-1:0];
         cpc_pkg::CSR_GREEN_LOW:  cal_lo[cpc_pkg::COLOR_GREEN] = data[CAL_W-1:0];
         cpc_pkg::CSR_GREEN_HIGH: cal_hi[cpc_pkg::COLOR_GREEN] = data[CAL_W-1:0];
         cpc_pkg::CSR_BLUE_LOW:   cal_lo[cpc_pkg::COLOR_BLUE] = data[CAL_W-1:0];
         cpc_pkg::CSR_BLUE_HIGH:  cal_hi[cpc_pkg::COLOR_BLUE] = data[CAL_W-1:0];
         cpc_pkg::CSR_SETTLE:     settle_cfg = data[SETTLE_W-1:0];
         default: ;
      endcase
   endfunction

   // Moves on to the next color, or classifies after blue. Returns 1 on completion.
   function automatic bit finish_color();
      if (meas_color != cpc_pkg::COLOR_BLUE) begin
         meas_color = meas_color + 2'd1;
         meas_phase = MP_SEEK_HIGH;
         return 1'b0;
      end
      red_flag = (mapped[cpc_pkg::COLOR_RED] > mapped[cpc_pkg::COLOR_GREEN]) &&
                 (mapped[cpc_pkg::COLOR_RED] > mapped[cpc_pkg::COLOR_BLUE]);
      meas_phase = MP_IDLE;
      return 1'b1;
   endfunction

   // Advances the predictor by one sample and returns the response it should produce.
   function automatic reading_type predict_reading(bit start, bit level);
      reading_type r;
      bit done;
      done = 1'b0;
      case (meas_phase)
         MP_IDLE: begin
            if (start) begin
               meas_color = cpc_pkg::COLOR_RED;
               meas_phase = MP_SEEK_HIGH;
            end
         end
         MP_SEEK_HIGH: if (level) meas_phase = MP_SEEK_FALL;
         MP_SEEK_FALL: begin
            if (!level) begin
               low_ticks = 64'sd1;
               meas_phase = MP_LOW;
            end
         end
         MP_LOW: begin
            if (!level) begin
               if (low_ticks < LOW_TICKS_MAX) low_ticks = low_ticks + 64'sd1;
            end else begin
               mapped[meas_color] = scale_count(low_ticks, longint'(cal_lo[meas_color]),
                                                longint'(cal_hi[meas_color]));
               settle_left = settle_cfg;
               if (settle_left == 0) done = finish_color();
               else meas_phase = MP_SETTLE;
            end
         end
         MP_SETTLE: begin
            if (settle_left != 0) settle_left = settle_left - 1'b1;
            if (settle_left == 0) done = finish_color();
         end
         default: meas_phase = MP_IDLE;
      endcase
      r.filter_s2 = (meas_color == cpc_pkg::COLOR_GREEN);
      r.filter_s3 = (meas_color == cpc_pkg::COLOR_GREEN) ||
                    (meas_color == cpc_pkg::COLOR_BLUE);
      r.busy = (meas_phase != MP_IDLE);
      r.done = done;
      r.red_detected = red_flag;
      r.red_value = mapped[cpc_pkg::COLOR_RED][VAL_W-1:0];
      r.green_value = mapped[cpc_pkg::COLOR_GREEN][VAL_W-1:0];
      r.blue_value = mapped[cpc_pkg::COLOR_BLUE][VAL_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic signed [VAL_W-1:0] want,
                                       logic signed [VAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_bit(string name, logic want, logic got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compares every accepted response with the oldest expected reading.
   always @(posedge clock) begin : check_responses
      reading_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            mismatch_count++;
         end else begin
            want = expected_readings.pop_front();
            check_bit("filter_s2", want.filter_s2, rsp_filter_s2);
            check_bit("filter_s3", want.filter_s3, rsp_filter_s3);
            check_bit("busy_res", want.busy, rsp_busy_res);
            check_bit("done_res", want.done, rsp_done_res);
            check_bit("red_detected", want.red_detected, rsp_red_detected);
            check_field("red_value", want.red_value, rsp_red_value);
            check_field("green_value", want.green_value, rsp_green_value);
            check_field("blue_value", want.blue_value, rsp_blue_value);
         end
      end
   end

   // Response stall pattern: stretches of random length, each stalled with a chance of one in three.
   always @(posedge clock) begin
      if (reset || gaps_off) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold != 0) begin
         stall_hold = stall_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_hold = pick_gap(40);
      end
   end

   // Ends the run when no handshake completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Sends one request and records the reading it should produce.
   task automatic send_sample(input bit start, input bit level);
      int unsigned gap;
      req_valid <= 1'b1;
      req_start_req <= start;
      req_sensor_level <= level;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_readings.push_back(predict_reading(start, level));
      sent_items++;
      gap = pick_gap(25);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [IDX_W-1:0] idx,
                                 input logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      store_register(idx, data);
      @(posedge clock);
   endtask

   // Stops sending and waits until every expected reading has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   // Feeds random samples until the sequencer is back in idle.
   task automatic finish_sequence();
      while (meas_phase != MP_IDLE) send_sample(coin(), coin());
   endtask

   // One color: low lead-in, high level, a low pulse of the given length, then settle.
   task automatic run_color_pulse(input int unsigned lows);
      repeat ($urandom_range(0, 3)) send_sample(coin(), 1'b0);
      repeat ($urandom_range(1, 3)) send_sample(coin(), 1'b1);
      repeat (lows) send_sample(coin(), 1'b0);
      send_sample(coin(), 1'b1);
      while (meas_phase == MP_SETTLE) send_sample(coin(), coin());
   endtask

   task automatic run_measurement(input int unsigned red_lows, input int unsigned green_lows,
                                  input int unsigned blue_lows);
      finish_sequence();
      send_sample(1'b1, coin());
      run_color_pulse(red_lows);
      run_color_pulse(green_lows);
      run_color_pulse(blue_lows);
   endtask

   function automatic int unsigned pick_low_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 12);
      if (r < 95) return $urandom_range(13, 80);
      return $urandom_range(81, 400);
   endfunction

   // Writes one color's limits: mostly a narrow normal window, sometimes inverted,
   // equal or anywhere. Upper data bits carry junk that the block must drop.
   task automatic write_limits(input logic [IDX_W-1:0] lo_idx,
                               input logic [IDX_W-1:0] hi_idx);
      int unsigned r;
      logic [CAL_W-1:0] lo, hi;
      logic [7:0] junk;
      r = $urandom_range(0, 19);
      if (r < 13) begin
         lo = CAL_W'($urandom_range(0, 30));
         hi = CAL_W'(lo + $urandom_range(1, 50));
      end else if (r < 16) begin
         hi = CAL_W'($urandom_range(0, 30));
         lo = CAL_W'(hi + $urandom_range(1, 50));
      end else if (r < 18) begin
         lo = CAL_W'($urandom_range(0, 65535));
         hi = lo;
      end else begin
         lo = CAL_W'($urandom_range(0, 65535));
         hi = CAL_W'($urandom_range(0, 65535));
      end
      junk = 8'($urandom_range(0, 255));
      write_register(lo_idx, {junk, lo});
      junk = 8'($urandom_range(0, 255));
      write_register(hi_idx, {junk, hi});
   endtask

   task automatic randomize_registers();
      int unsigned r;
      write_limits(cpc_pkg::CSR_RED_LOW, cpc_pkg::CSR_RED_HIGH);
      write_limits(cpc_pkg::CSR_GREEN_LOW, cpc_pkg::CSR_GREEN_HIGH);
      write_limits(cpc_pkg::CSR_BLUE_LOW, cpc_pkg::CSR_BLUE_HIGH);
      r = $urandom_range(0, 99);
      if (r < 30) write_register(cpc_pkg::CSR_SETTLE, '0);
      else if (r < 85) write_register(cpc_pkg::CSR_SETTLE, DATA_W'($urandom_range(1, 4)));
      else write_register(cpc_pkg::CSR_SETTLE, DATA_W'($urandom_range(5, 20)));
   endtask

   // Outputs right after reset, with no start request.
   task automatic test_idle_outputs();
      repeat (4) send_sample(1'b0, coin());
   endtask

   // Reset calibration limits, a one-tick low pulse and starts while busy.
   task automatic test_reset_calibration();
      wait_for_results();
      write_register(cpc_pkg::CSR_SETTLE, '0);
      run_measurement(1, 2, 3);
   endtask

   // Full-range, inverted and equal limits.
   task automatic test_calibration_extremes();
      wait_for_results();
      write_register(cpc_pkg::CSR_RED_LOW, 24'd0);
      write_register(cpc_pkg::CSR_RED_HIGH, 24'd65535);
      write_register(cpc_pkg::CSR_GREEN_LOW, 24'd65535);
      write_register(cpc_pkg::CSR_GREEN_HIGH, 24'd0);
      write_register(cpc_pkg::CSR_BLUE_LOW, 24'd65535);
      write_register(cpc_pkg::CSR_BLUE_HIGH, 24'd65535);
      write_register(cpc_pkg::CSR_SETTLE, 24'd1);
      run_measurement(5, 7, 2);
      wait_for_results();
      write_register(cpc_pkg::CSR_RED_LOW, 24'd0);
      write_register(cpc_pkg::CSR_RED_HIGH, 24'd1);
      write_register(cpc_pkg::CSR_GREEN_LOW, 24'd0);
      write_register(cpc_pkg::CSR_GREEN_HIGH, 24'd0);
      write_register(cpc_pkg::CSR_BLUE_LOW, 24'd65535);
      write_register(cpc_pkg::CSR_BLUE_HIGH, 24'd65534);
      run_measurement(9, 1, 4);
   endtask

   // Unused index and upper data bits on the 16-bit registers are dropped.
   task automatic test_register_masking();
      wait_for_results();
      write_register(CSR_UNUSED, 24'hFFFFFF);
      write_register(cpc_pkg::CSR_RED_LOW, 24'hFF0002);
      write_register(cpc_pkg::CSR_RED_HIGH, 24'hAA0014);
      write_register(cpc_pkg::CSR_GREEN_LOW, 24'h55000A);
      write_register(cpc_pkg::CSR_GREEN_HIGH, 24'hFF0020);
      write_register(cpc_pkg::CSR_BLUE_LOW, 24'hC30001);
      write_register(cpc_pkg::CSR_BLUE_HIGH, 24'h3C0011);
      write_register(cpc_pkg::CSR_SETTLE, 24'h000002);
      run_measurement(3, 6, 12);
   endtask

   // Largest settle time while waiting for a pulse, then settle changes between colors.
   task automatic test_settle_extremes();
      wait_for_results();
      write_register(cpc_pkg::CSR_SETTLE, 24'hFFFFFF);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
      wait_for_results();
      write_register(cpc_pkg::CSR_SETTLE, 24'd0);
      run_color_pulse(4);
      wait_for_results();
      write_register(cpc_pkg::CSR_SETTLE, 24'd1);
      run_color_pulse(2);
      wait_for_results();
      write_register(cpc_pkg::CSR_SETTLE, 24'd5);
      run_color_pulse(3);
   endtask

   // Mostly well-formed measurements with random limits, plus broken sequences,
   // register changes between colors and raw noise.
   task automatic test_random_measurements();
      int unsigned sel;
      logic [IDX_W-1:0] idx;
      logic [DATA_W-1:0] data;
      while (sent_items < TOTAL_ITEMS) begin
         sel = $urandom_range(0, 9);
         gaps_off = ($urandom_range(0, 5) == 0);
         if (sel < 2) begin
            wait_for_results();
            randomize_registers();
         end
         if (sel < 7) begin
            run_measurement(pick_low_count(), pick_low_count(), pick_low_count());
         end else if (sel == 7) begin
            finish_sequence();
            send_sample(1'b1, coin());
            repeat ($urandom_range(1, 30)) send_sample(coin(), coin());
         end else if (sel == 8) begin
            finish_sequence();
            send_sample(1'b1, coin());
            run_color_pulse(pick_low_count());
            wait_for_results();
            idx = IDX_W'($urandom_range(cpc_pkg::CSR_RED_LOW, cpc_pkg::CSR_BLUE_HIGH));
            data = DATA_W'($urandom);
            write_register(idx, data);
            run_color_pulse(pick_low_count());
            run_color_pulse(pick_low_count());
         end else begin
            repeat ($urandom_range(1, 20)) send_sample(coin(), coin());
         end
      end
      gaps_off = 1'b0;
   endtask

   initial begin
      reset_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_idle_outputs();
      test_reset_calibration();
      test_calibration_extremes();
      test_register_masking();
      test_settle_extremes();
      test_random_measurements();
      wait_for_results();
      repeat (END_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
